[rtl/core/onenc_pkg.sv]
package onenc_pkg;

  // Default widths
  localparam int unsigned COMPONENT_WIDTH_DEF = 16;
  localparam int unsigned CODE_WIDTH_DEF      = 16;

  // Fixed output word
  localparam int unsigned PACKED_WIDTH = 32;

  // Control that travels alongside the data from the front-end output through every division cell
  typedef struct packed {
    logic valid;
    logic zero;
  } onenc_ctrl_t;

endpackage

[rtl/core/onenc_prep.sv]
// Front end: magnitudes, L1 norm, fold select, numerators scaled by code max.
module onenc_prep import onenc_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int unsigned CODE_WIDTH      = CODE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_z_i,
  output onenc_ctrl_t                           ctrl_o,
  output logic [COMPONENT_WIDTH+1:0]            den_o,
  output logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] num_u_o,
  output logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] num_v_o
);

  localparam int unsigned MW = COMPONENT_WIDTH;      // magnitude
  localparam int unsigned LW = COMPONENT_WIDTH + 1;  // L1 norm
  localparam int unsigned DW = COMPONENT_WIDTH + 2;  // 2L and numerators
  localparam int unsigned NW = DW + CODE_WIDTH;      // scaled numerators

  // stage 1: magnitudes and signs
  logic          s1_valid_q;
  logic [MW-1:0] ax_q, ay_q, az_q;
  logic          xneg_q, yneg_q, zneg_q;

  // stage 2: denominator and numerators
  logic          s2_valid_q, s2_zero_q;
  logic [DW-1:0] den2_q, nu_q, nv_q;
  logic [LW-1:0] l1_d;
  logic [DW-1:0] den_d, lx_d, nu_d, nv_d;

  // stage 3: numerators times code max
  onenc_ctrl_t   s3_ctrl_q;
  logic [DW-1:0] den3_q;
  logic [NW-1:0] num_u_q, num_v_q;
  logic [NW-1:0] nu_ext, nv_ext;

  function automatic logic [MW-1:0] magn(logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(~v + 1'b1) : MW'(v);
  endfunction

  always_comb begin
    l1_d  = LW'(ax_q) + LW'(ay_q) + LW'(az_q);
    den_d = {l1_d, 1'b0};
    lx_d  = DW'(l1_d);
    if (zneg_q) begin
      nu_d = xneg_q ? DW'(ay_q) : den_d - DW'(ay_q);
      nv_d = yneg_q ? DW'(ax_q) : den_d - DW'(ax_q);
    end else begin
      nu_d = xneg_q ? lx_d - DW'(ax_q) : lx_d + DW'(ax_q);
      nv_d = yneg_q ? lx_d - DW'(ay_q) : lx_d + DW'(ay_q);
    end
  end

  assign nu_ext = NW'(nu_q);
  assign nv_ext = NW'(nv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_ctrl_q  <= '0;
    end else if (en_i) begin
      s1_valid_q      <= valid_i;
      s2_valid_q      <= s1_valid_q;
      s3_ctrl_q.valid <= s2_valid_q;
      s3_ctrl_q.zero  <= s2_zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q      <= magn(comp_x_i);
      ay_q      <= magn(comp_y_i);
      az_q      <= magn(comp_z_i);
      xneg_q    <= comp_x_i[MW-1];
      yneg_q    <= comp_y_i[MW-1];
      zneg_q    <= comp_z_i[MW-1];
      den2_q    <= den_d;
      nu_q      <= nu_d;
      nv_q      <= nv_d;
      s2_zero_q <= (l1_d == '0);
      den3_q    <= den2_q;
      // n * (2^CW - 1) = (n << CW) - n
      num_u_q   <= (nu_ext << CODE_WIDTH) - nu_ext;
      num_v_q   <= (nv_ext << CODE_WIDTH) - nv_ext;
    end
  end

  assign ctrl_o  = s3_ctrl_q;
  assign den_o   = den3_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;

endmodule

[rtl/core/onenc_div_cell.sv]
// One restoring-division step for u and v; quotient bit shifts in at the bottom.
module onenc_div_cell import onenc_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int unsigned CODE_WIDTH      = CODE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  onenc_ctrl_t                           ctrl_i,
  input  logic [COMPONENT_WIDTH+1:0]            den_i,
  input  logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] acc_u_i,
  input  logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] acc_v_i,
  output onenc_ctrl_t                           ctrl_o,
  output logic [COMPONENT_WIDTH+1:0]            den_o,
  output logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] acc_u_o,
  output logic [COMPONENT_WIDTH+CODE_WIDTH+1:0] acc_v_o
);

  localparam int unsigned DW = COMPONENT_WIDTH + 2;
  localparam int unsigned CW = CODE_WIDTH;
  localparam int unsigned AW = DW + CW;

  onenc_ctrl_t   ctrl_q;
  logic [DW-1:0] den_q;
  logic [AW-1:0] acc_u_q, acc_v_q;
  logic [AW-1:0] acc_u_d, acc_v_d;

  // acc = {partial remainder, pending dividend / quotient bits}
  function automatic logic [AW-1:0] step(logic [AW-1:0] acc, logic [DW-1:0] den);
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    t    = {acc[AW-1:CW], acc[CW-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    return {(ge ? diff[DW-1:0] : t[DW-1:0]), acc[CW-2:0], ge};
  endfunction

  assign acc_u_d = step(acc_u_i, den_i);
  assign acc_v_d = step(acc_v_i, den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q   <= den_i;
      acc_u_q <= acc_u_d;
      acc_v_q <= acc_v_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign den_o   = den_q;
  assign acc_u_o = acc_u_q;
  assign acc_v_o = acc_v_q;

endmodule

[rtl/core/octahedral_normal_encoder.sv]
// Channel   | Dir | Signals                  | Payload
// ----------+-----+--------------------------+------------------------------------------
// s_axis    | in  | tvalid, tready, tdata    | comp_x, comp_y, comp_z (signed, LSB first)
// m_axis    | out | tvalid, tready, tdata,   | tdata: packed_code (u low, v high)
//           |     | tuser                    | tuser: zero_vector
//
// One transaction in per cycle, one out per cycle, while the pipe is not stalled.
// Stages: three front-end stages, one division cell per code bit, output reg.
// The whole pipe advances while the output register is empty or being taken, so
// s_axis_tready_o follows m_axis_tready_i when the output holds data.
// Reset (rst_ni low, async) clears valid and pipeline control bits only; data registers are not reset.
module octahedral_normal_encoder import onenc_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int unsigned CODE_WIDTH      = CODE_WIDTH_DEF,
  localparam int unsigned IN_DATA_WIDTH  = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // comp_x, comp_y, comp_z from bit 0 up, zero padded to bytes
  input  logic [IN_DATA_WIDTH-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // packed_code
  output logic [PACKED_WIDTH-1:0]  m_axis_tdata_o,
  // zero_vector
  output logic                     m_axis_tuser_o
);

  localparam int unsigned CPW = COMPONENT_WIDTH;
  localparam int unsigned DW  = COMPONENT_WIDTH + 2;
  localparam int unsigned CW  = CODE_WIDTH;
  localparam int unsigned AW  = DW + CW;
  localparam int unsigned PW  = 2 * CW;
  localparam logic [CW-1:0] MID_CODE = {1'b0, {(CW-1){1'b1}}};

  logic adv;

  // division chain taps: index 0 is the front end, CW is the last cell
  onenc_ctrl_t   ctrl_s  [CW+1];
  logic [DW-1:0] den_s   [CW+1];
  logic [AW-1:0] acc_u_s [CW+1];
  logic [AW-1:0] acc_v_s [CW+1];

  logic          m_valid_q;
  logic          m_zero_q;
  logic [CW-1:0] m_u_q, m_v_q;
  logic [PW-1:0] packed_full;

  // global stall: move when the output slot frees up
  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  onenc_prep #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .CODE_WIDTH      (CODE_WIDTH)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s_axis_tvalid_i),
    .comp_x_i (s_axis_tdata_i[CPW-1:0]),
    .comp_y_i (s_axis_tdata_i[2*CPW-1:CPW]),
    .comp_z_i (s_axis_tdata_i[3*CPW-1:2*CPW]),
    .ctrl_o   (ctrl_s[0]),
    .den_o    (den_s[0]),
    .num_u_o  (acc_u_s[0]),
    .num_v_o  (acc_v_s[0])
  );

  // one cell per quotient bit, MSB first
  for (genvar i = 0; i < CW; i++) begin : g_cell
    onenc_div_cell #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .CODE_WIDTH      (CODE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .ctrl_i  (ctrl_s[i]),
      .den_i   (den_s[i]),
      .acc_u_i (acc_u_s[i]),
      .acc_v_i (acc_v_s[i]),
      .ctrl_o  (ctrl_s[i+1]),
      .den_o   (den_s[i+1]),
      .acc_u_o (acc_u_s[i+1]),
      .acc_v_o (acc_v_s[i+1])
    );
  end

  // output register; zero vector forces the midpoint code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= ctrl_s[CW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_zero_q <= ctrl_s[CW].zero;
      m_u_q    <= ctrl_s[CW].zero ? MID_CODE : acc_u_s[CW][CW-1:0];
      m_v_q    <= ctrl_s[CW].zero ? MID_CODE : acc_v_s[CW][CW-1:0];
    end
  end

  assign packed_full = {m_v_q, m_u_q};

  if (PW >= PACKED_WIDTH) begin : g_pack_trunc
    assign m_axis_tdata_o = packed_full[PACKED_WIDTH-1:0];
  end else begin : g_pack_ext
    assign m_axis_tdata_o = PACKED_WIDTH'(packed_full);
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_zero_q;

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import onenc_pkg::*;

  localparam int unsigned COMP_W   = COMPONENT_WIDTH_DEF;
  localparam int unsigned CODE_W   = CODE_WIDTH_DEF;
  localparam int unsigned IN_W     = ((3 * COMP_W + 7) / 8) * 8;
  localparam longint      CODE_MAX = (64'd1 << CODE_W) - 1;
  localparam longint      CODE_MID = CODE_MAX >> 1;
  // pipe depth: front end, one cell per code bit, output register
  localparam int unsigned PIPE_LATENCY = CODE_W + 4;
  localparam int unsigned ITEMS_PER_MODE = 470;
  localparam int unsigned HOLD_ITEMS     = 60;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned MAX_REPORTS    = 10;

  // Handshake idling profiles, as percent of cycles
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One direction vector; x sits in the low bits of tdata
  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } direction_t;

  // Expected octahedral codes, oldest first
  class code_scoreboard;
    typedef struct {
      logic [PACKED_WIDTH-1:0] code;
      logic                    zero;
    } code_t;

    code_t pending_codes[$];
    int    mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact rational encode: each code is floor(n * CODE_MAX / 2L)
    function void note_vector(direction_t dir);
      longint x, y, z;
      longint ax, ay, az, l1, d, nu, nv, u, v;
      code_t  e;
      x  = longint'(dir.x);
      y  = longint'(dir.y);
      z  = longint'(dir.z);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      l1 = ax + ay + az;
      if (l1 == 0) begin
        // no direction at all: midpoint code and the flag
        u      = CODE_MID;
        v      = CODE_MID;
        e.zero = 1'b1;
      end else begin
        d = 2 * l1;
        if (z < 0) begin
          // lower hemisphere folds onto the outer triangles; zero counts positive
          nu = (x >= 0) ? d - ay : ay;
          nv = (y >= 0) ? d - ax : ax;
        end else begin
          nu = x + l1;
          nv = y + l1;
        end
        u      = (nu * CODE_MAX) / d;
        v      = (nv * CODE_MAX) / d;
        e.zero = 1'b0;
      end
      e.code = PACKED_WIDTH'(((v & CODE_MAX) << CODE_W) | (u & CODE_MAX));
      pending_codes.push_back(e);
    endfunction

    function void check_code(logic [PACKED_WIDTH-1:0] code, logic zero);
      code_t e;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected code %h zero %b with nothing pending", code, zero);
        return;
      end
      e = pending_codes.pop_front();
      if (code !== e.code || zero !== e.zero) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("code mismatch: expected code %h zero %b, got code %h zero %b",
                   e.code, e.zero, code, zero);
      end
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_W-1:0]         s_axis_tdata_i  = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [PACKED_WIDTH-1:0] m_axis_tdata_o;
  logic                    m_axis_tuser_o;

  code_scoreboard sb;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  logic           hold_off       = 1'b0;

  always #5 clk_i = ~clk_i;

  octahedral_normal_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Receiver: random stalls per the current profile, or a forced hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off)
      m_axis_tready_i <= 1'b0;
    else
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: values read here are the pre-edge ones, so no ordering race
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_vector(direction_t'(s_axis_tdata_i[3*COMP_W-1:0]));
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_code(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  function automatic void set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 12;
        recv_stall_pct = 12;
      end
    endcase
  endfunction

  // Mix of full-range, tiny, extreme and lower-hemisphere vectors
  function automatic direction_t random_direction();
    direction_t  dir;
    logic [15:0] extremes [5];
    int unsigned kind;
    extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    kind     = $urandom_range(9);
    dir.x    = COMP_W'($urandom);
    dir.y    = COMP_W'($urandom);
    dir.z    = COMP_W'($urandom);
    case (kind)
      4, 5: begin
        dir.x = COMP_W'(int'($urandom_range(16)) - 8);
        dir.y = COMP_W'(int'($urandom_range(16)) - 8);
        dir.z = COMP_W'(int'($urandom_range(16)) - 8);
      end
      6: begin
        dir.x = extremes[$urandom_range(4)];
        dir.y = extremes[$urandom_range(4)];
        dir.z = extremes[$urandom_range(4)];
      end
      7: begin
        dir.x = COMP_W'(int'($urandom_range(32768)) - 16384);
        dir.y = COMP_W'(int'($urandom_range(32768)) - 16384);
        dir.z = COMP_W'(-int'($urandom_range(32768, 1)));
      end
      8: dir.z = COMP_W'(-int'($urandom_range(32768, 1)));
      9: begin
        // a zero coordinate on the fold, where the sign tie matters
        if ($urandom_range(1)) dir.x = '0;
        else dir.y = '0;
        dir.z = COMP_W'(-int'($urandom_range(32768, 1)));
      end
      default: ;
    endcase
    return dir;
  endfunction

  // Offer one vector, returning at the edge where the transaction is taken
  task automatic send_vector(direction_t dir);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'(dir);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_vector(random_direction());
    s_axis_tvalid_i <= 1'b0;
  endtask

  // one edge first so the monitor has logged the last accepted vector
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic hold_receiver(int unsigned cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  endtask

  task automatic send_directed();
    direction_t dirs [$];
    dirs = '{
      '{z: 16'sd0,      y: 16'sd0,      x: 16'sd0},       // zero vector
      '{z: 16'sd0,      y: 16'sd0,      x: 16'sd32767},
      '{z: 16'sd0,      y: 16'sd0,      x: -16'sd32768},
      '{z: 16'sd0,      y: 16'sd32767,  x: 16'sd0},
      '{z: 16'sd0,      y: -16'sd32768, x: 16'sd0},
      '{z: 16'sd32767,  y: 16'sd0,      x: 16'sd0},
      '{z: -16'sd32768, y: 16'sd0,      x: 16'sd0},       // fold at the pole
      '{z: -16'sd32768, y: -16'sd32768, x: -16'sd32768},  // largest L1
      '{z: 16'sd32767,  y: 16'sd32767,  x: 16'sd32767},
      '{z: 16'sd32767,  y: -16'sd32768, x: -16'sd32768},
      '{z: -16'sd32768, y: -16'sd32768, x: 16'sd32767},
      '{z: -16'sd1,     y: 16'sd32767,  x: -16'sd32768},
      '{z: -16'sd1,     y: 16'sd1,      x: 16'sd1},
      '{z: -16'sd1,     y: -16'sd1,     x: -16'sd1},
      '{z: -16'sd1,     y: -16'sd1,     x: 16'sd0},       // zero x on the fold
      '{z: -16'sd1,     y: 16'sd0,      x: -16'sd1},      // zero y on the fold
      '{z: 16'sd0,      y: 16'sd0,      x: 16'sd1},
      '{z: 16'sd1,      y: 16'sd0,      x: 16'sd0},
      '{z: -16'sd1,     y: 16'sd0,      x: 16'sd0},
      '{z: 16'sd0,      y: 16'sd1,      x: -16'sd1},
      '{z: 16'sd12345,  y: -16'sd23456, x: 16'sd3456},
      '{z: -16'sd21845, y: 16'sd21845,  x: -16'sd21846}
    };
    foreach (dirs[i]) send_vector(dirs[i]);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Run limit: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("octahedral_normal_encoder verification failed");
    $finish;
  end

  initial begin
    sb = new();
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    wait_drained();

    // Long receiver hold-off while the sender keeps pushing: pipe fills and
    // backpressure reaches s_axis_tready_o
    fork
      hold_receiver(HOLD_CYCLES);
      send_random(HOLD_ITEMS);
    join
    // sender pause until everything is out
    wait_drained();

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      set_idle(idle_mode_e'(m));
      send_random(ITEMS_PER_MODE);
      wait_drained();
    end

    set_idle(IDLE_NONE);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("octahedral_normal_encoder verification clean");
    else
      $display("octahedral_normal_encoder verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/onenc_pkg.sv
rtl/core/onenc_prep.sv
rtl/core/onenc_div_cell.sv
rtl/core/octahedral_normal_encoder.sv
tb/sv/testbench.sv
